@@ hdl/irc_pkg.sv @@
// ----------------------------------------------------------------------------
// irc_pkg: shared types and constants for the image receiver CRC-32 check
// Word layouts, request and status codes, and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package irc_pkg;

    // Reflected CRC-32 polynomial and seed
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Request codes
    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_ABORT = 2'd2;

    // Status codes
    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_CRCBYTE = 3'd1;
    localparam logic [2:0] ST_PASS    = 3'd2;
    localparam logic [2:0] ST_FAIL    = 3'd3;
    localparam logic [2:0] ST_ABORTED = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;
    localparam logic [2:0] ST_STARTED = 3'd6;

    // Number of trailing CRC bytes
    localparam logic [2:0] TAIL_BYTES = 3'd4;

    // Input word
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic [31:0] computed_crc;
    } t_out_word;

    // One byte folded into the running CRC register, LSB first
    function automatic logic [31:0] crc_fold(input logic [31:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [31:0] c;
        c = {24'd0, crc_in[7:0] ^ byte_in};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return (crc_in >> 8) ^ c;
    endfunction

endpackage

@@ hdl/irc_engine.sv @@
// ----------------------------------------------------------------------------
// irc_engine: transfer state and per-word decision logic
// Holds byte count, CRC register, trailing byte gather and phase. Updates them
// on each processed word and produces that word's result combinationally.
// ----------------------------------------------------------------------------
module irc_engine
    import irc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_in_word    i_word,
    input  logic [31:0] i_image_size,
    output t_out_word   o_result
);

    // Phase codes
    localparam logic [1:0] PH_RECV  = 2'd0;
    localparam logic [1:0] PH_DONE  = 2'd1;
    localparam logic [1:0] PH_ABORT = 2'd2;

    logic [31:0] r_byte_count, n_byte_count;
    logic [31:0] r_crc,        n_crc;
    logic [31:0] r_tail_shift, n_tail_shift;
    logic [2:0]  r_tail_count, n_tail_count;
    logic [1:0]  r_phase,      n_phase;

    logic [2:0]  status;
    logic [7:0]  fwd_byte;

    // Next state and result for the word at the head of the pipe
    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_tail_shift = r_tail_shift;
        n_tail_count = r_tail_count;
        n_phase      = r_phase;
        status       = ST_IGNORED;
        fwd_byte     = 8'd0;
        case (i_word.req_type)
            REQ_START: begin
                n_byte_count = 32'd0;
                n_crc        = CRC_INIT;
                n_tail_shift = 32'd0;
                n_tail_count = 3'd0;
                n_phase      = PH_RECV;
                status       = ST_STARTED;
            end
            REQ_ABORT: begin
                n_phase = PH_ABORT;
                status  = ST_ABORTED;
            end
            REQ_DATA: begin
                if (r_phase == PH_RECV) begin
                    if (r_tail_count == 3'd0 && r_byte_count < i_image_size) begin
                        // payload byte
                        n_crc        = crc_fold(r_crc, i_word.data_byte);
                        n_byte_count = r_byte_count + 32'd1;
                        status       = ST_PAYLOAD;
                        fwd_byte     = i_word.data_byte;
                    end else begin
                        // trailing CRC byte, little-endian
                        n_tail_shift = {i_word.data_byte, r_tail_shift[31:8]};
                        n_tail_count = r_tail_count + 3'd1;
                        if (n_tail_count >= TAIL_BYTES) begin
                            n_phase = PH_DONE;
                            status  = (n_tail_shift == ~r_crc) ? ST_PASS : ST_FAIL;
                        end else begin
                            status = ST_CRCBYTE;
                        end
                    end
                end
            end
            default: begin
                status = ST_IGNORED;
            end
        endcase
    end

    assign o_result.status       = status;
    assign o_result.payload_byte = fwd_byte;
    assign o_result.computed_crc = ~n_crc;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 32'd0;
            r_crc        <= CRC_INIT;
            r_tail_shift <= 32'd0;
            r_tail_count <= 3'd0;
            r_phase      <= PH_RECV;
        end else if (i_fire) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_tail_shift <= n_tail_shift;
            r_tail_count <= n_tail_count;
            r_phase      <= n_phase;
        end
    end

    // Tail gather never runs past four bytes while still receiving
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RECV |-> r_tail_count < TAIL_BYTES)
        else $error("tail count overran while receiving");

    // Payload bytes stop once the first CRC byte is taken
    a_no_payload_after_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_tail_count != 3'd0 |-> status != ST_PAYLOAD)
        else $error("payload byte accepted after CRC bytes began");

    // Phase stays within its defined codes
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RECV || r_phase == PH_DONE || r_phase == PH_ABORT)
        else $error("illegal phase code");

endmodule

@@ hdl/image_receiver_crc32_check.sv @@
// ----------------------------------------------------------------------------
// image_receiver_crc32_check: firmware image receiver with CRC-32 check
// Forwards payload bytes and checks the trailing little-endian CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one request
//   word per transfer: data byte, start new transfer, or link lost abort.
//   Output channel (o_out_valid / i_out_stall / o_out_word) returns exactly
//   one result word per request: status, forwarded byte and current CRC.
//   i_cfg_we / i_cfg_wdata load the payload length; write only while idle.
//   Path: a word accepted into the input register is processed into the result
//   register when the result register is empty or being drained.
//   Throughput: one word per cycle while the output is not stalled; the byte-wide
//   CRC fold is combinational logic between the input register and the result register.
//   Reset (synchronous, active low) empties both registers, clears the
//   transfer state and sets the payload length to zero.
//   When the receiver stalls, the result holds, the input register fills,
//   and o_in_stall rises once both are occupied.
// ----------------------------------------------------------------------------
module image_receiver_crc32_check
    import irc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    logic [31:0] r_image_size;
    logic        r_in_valid;
    t_in_word    r_in_word;
    logic        r_out_valid;
    t_out_word   r_out_word;

    t_out_word   result;
    logic        advance;
    logic        in_take;

    // Pipe control
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= 32'd0;
        end else if (i_cfg_we) begin
            r_image_size <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    irc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_word       (r_in_word),
        .i_image_size (r_image_size),
        .o_result     (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // An empty input register never back-pressures
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("stall raised with empty input register");

    // Forwarded byte is only nonzero on payload words
    a_fwd_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_PAYLOAD |-> o_out_word.payload_byte == 8'd0)
        else $error("forwarded byte on non-payload word");

    // A start result reports the CRC of no bytes
    a_start_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_STARTED |-> o_out_word.computed_crc == 32'd0)
        else $error("start result with nonzero CRC");

endmodule
